// ----- design/rtlog_pkg.sv -----
// rtlog_pkg: shared constants, command and register codes, and types for the
// log-odds occupancy grid block. No dependencies.
`timescale 1ns / 1ps

package rtlog_pkg;

    // default sizes, handed to the top level parameters
    localparam int DEF_MAX_COLS  = 512;
    localparam int DEF_MAX_ROWS  = 512;
    localparam int DEF_ODDS_BITS = 16;

    // fixed field widths
    localparam int COORD_W    = 12;
    localparam int STEP_W     = 16;
    localparam int SIZE_W     = 10;
    localparam int CMD_W      = 2;
    localparam int VALUE_W    = 16;
    localparam int TOUCH_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // stream packing
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    // commands
    localparam logic [CMD_W-1:0] CMD_RAY   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCCUPIED_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ODDS_FLOOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ODDS_CEILING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS   = 3'd5;

    // register reset values
    localparam logic signed [STEP_W-1:0] RST_FREE_STEP     = -16'sd102;
    localparam logic signed [STEP_W-1:0] RST_OCCUPIED_STEP = 16'sd217;
    localparam logic signed [STEP_W-1:0] RST_ODDS_FLOOR    = -16'sd1280;
    localparam logic signed [STEP_W-1:0] RST_ODDS_CEILING  = 16'sd1280;
    localparam logic [SIZE_W-1:0]        RST_ACTIVE_COLS   = 10'd512;
    localparam logic [SIZE_W-1:0]        RST_ACTIVE_ROWS   = 10'd512;

    // status of the cell the line walker presents
    typedef struct packed {
        logic valid;
        logic last;
    } rtlog_cell_t;

endpackage

// ----- design/rtlog_odds_mem.sv -----
// rtlog_odds_mem: single-port-read, single-port-write cell store with
// registered read data. Uses rtlog_pkg for its default parameter sizes.
`timescale 1ns / 1ps

module rtlog_odds_mem
    import rtlog_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_COLS * DEF_MAX_ROWS,
    parameter int ADDR_W = $clog2(DEF_MAX_COLS * DEF_MAX_ROWS),
    parameter int WIDTH  = DEF_ODDS_BITS
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/rtlog_cell_update.sv -----
// rtlog_cell_update: shared add-and-clamp unit applied to one cell per cycle.
// Depends on rtlog_pkg for the step width.
`timescale 1ns / 1ps

module rtlog_cell_update
    import rtlog_pkg::*;
#(
    parameter int ODDS_BITS = DEF_ODDS_BITS
) (
    input  logic signed [ODDS_BITS-1:0] old_value,
    input  logic signed [STEP_W-1:0]    step,
    input  logic signed [STEP_W-1:0]    odds_floor,
    input  logic signed [STEP_W-1:0]    odds_ceiling,
    output logic signed [ODDS_BITS-1:0] new_value
);

    localparam int SUM_W = ((ODDS_BITS > STEP_W) ? ODDS_BITS : STEP_W) + 1;
    localparam logic signed [SUM_W-1:0] HI_LIM =
        SUM_W'({1'b0, {(ODDS_BITS-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] LO_LIM = -HI_LIM - SUM_W'(1);

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] ceil_e;
    logic signed [SUM_W-1:0] floor_e;
    logic signed [SUM_W-1:0] capped;
    logic signed [SUM_W-1:0] raised;
    logic signed [SUM_W-1:0] sat;

    always_comb begin
        sum     = SUM_W'(old_value) + SUM_W'(step);
        ceil_e  = SUM_W'(odds_ceiling);
        floor_e = SUM_W'(odds_floor);
        // ceiling first, then floor, so the floor wins when they cross
        capped  = (sum > ceil_e) ? ceil_e : sum;
        raised  = (capped < floor_e) ? floor_e : capped;
        if (raised > HI_LIM) begin
            sat = HI_LIM;
        end else if (raised < LO_LIM) begin
            sat = LO_LIM;
        end else begin
            sat = raised;
        end
        new_value = sat[ODDS_BITS-1:0];
    end

endmodule

// ----- design/rtlog_line_walker.sv -----
// rtlog_line_walker: Bresenham stepper, presents one grid cell per cycle from
// the start cell to the end cell. Depends on rtlog_pkg for the cell status type.
`timescale 1ns / 1ps

module rtlog_line_walker
    import rtlog_pkg::*;
#(
    parameter int COL_W = $clog2(DEF_MAX_COLS),
    parameter int ROW_W = $clog2(DEF_MAX_ROWS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  logic [COL_W-1:0] start_col,
    input  logic [ROW_W-1:0] start_row,
    input  logic [COL_W-1:0] end_col,
    input  logic [ROW_W-1:0] end_row,
    output rtlog_cell_t      cur_cell,
    output logic [COL_W-1:0] cell_col,
    output logic [ROW_W-1:0] cell_row
);

    localparam int D_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int ERR_W = D_W + 3;
    localparam int E2_W  = ERR_W + 1;

    logic                    active_reg, active_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [COL_W-1:0]        tcol_reg, tcol_next;
    logic [ROW_W-1:0]        trow_reg, trow_next;
    logic [D_W-1:0]          dx_reg, dx_next;
    logic [D_W-1:0]          dy_reg, dy_next;
    logic                    sx_neg_reg, sx_neg_next;
    logic                    sy_neg_reg, sy_neg_next;
    logic signed [ERR_W-1:0] err_reg, err_next;

    logic                    at_end;
    logic signed [E2_W-1:0]  e2;
    logic signed [E2_W-1:0]  dx_w;
    logic signed [E2_W-1:0]  dy_w;
    logic                    move_x;
    logic                    move_y;

    assign at_end = (col_reg == tcol_reg) && (row_reg == trow_reg);

    always_comb begin
        e2     = {err_reg, 1'b0};
        dx_w   = $signed(E2_W'(dx_reg));
        dy_w   = $signed(E2_W'(dy_reg));
        move_x = e2 > -dy_w;
        move_y = e2 < dx_w;

        active_next = active_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        tcol_next   = tcol_reg;
        trow_next   = trow_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        err_next    = err_reg;

        if (load) begin
            active_next = 1'b1;
            col_next    = start_col;
            row_next    = start_row;
            tcol_next   = end_col;
            trow_next   = end_row;
            dx_next     = D_W'((end_col > start_col) ? end_col - start_col
                                                     : start_col - end_col);
            dy_next     = D_W'((end_row > start_row) ? end_row - start_row
                                                     : start_row - end_row);
            sx_neg_next = !(start_col < end_col);
            sy_neg_next = !(start_row < end_row);
            err_next    = $signed(ERR_W'(dx_next)) - $signed(ERR_W'(dy_next));
        end else if (active_reg) begin
            if (at_end) begin
                active_next = 1'b0;
            end else begin
                err_next = err_reg
                         - (move_x ? $signed(ERR_W'(dy_reg)) : ERR_W'(0))
                         + (move_y ? $signed(ERR_W'(dx_reg)) : ERR_W'(0));
                if (move_x) begin
                    col_next = sx_neg_reg ? col_reg - COL_W'(1) : col_reg + COL_W'(1);
                end
                if (move_y) begin
                    row_next = sy_neg_reg ? row_reg - ROW_W'(1) : row_reg + ROW_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg    <= col_next;
        row_reg    <= row_next;
        tcol_reg   <= tcol_next;
        trow_reg   <= trow_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
        err_reg    <= err_next;
    end

    assign cur_cell.valid = active_reg;
    assign cur_cell.last  = at_end;
    assign cell_col       = col_reg;
    assign cell_row       = row_reg;

endmodule

// ----- design/ray_trace_log_odds_grid_update.sv -----
// ray_trace_log_odds_grid_update: top level of the log-odds occupancy grid.
// Uses rtlog_pkg, rtlog_line_walker, rtlog_cell_update and rtlog_odds_mem.
//
// Usage:
//   s_* carries one request: s_tuser is the command (ray, read, clear),
//   s_tdata the start and end cells. m_* returns exactly one result per
//   request: m_tdata holds the cell value and the touched-cell count, m_tuser
//   the in-grid flag. cfg_* writes the step, clamp and grid size registers;
//   the user does so only while the block is idle; the block does not enforce it.
// Sequence (from the accepting edge to the result being loaded):
//   ray: DECODE, RAY, DRAIN, DONE; the walker and the read-modify-write unit
//     handle one cell per cycle through the store's one read and one write port
//   request with its cells outside the grid, unused command: DECODE, DONE
//   read inside the grid: DECODE, READ (one registered store read), DONE
//   clear: DECODE, CLEAR, DONE; the store is zeroed one cell per cycle in CLEAR
// One request is in work at a time; s_tready is high only between requests.
// Reset: aresetn is synchronous, active low. Afterwards the block runs a
//   clearing pass over all MAX_COLS*MAX_ROWS cells with s_tready low; cfg
//   writes are taken during it, as cfg_ready is always high.
// Stall: a result waits in the output register while m_tready is low; the
//   next request may be accepted and worked on meanwhile, and its result
//   waits until the register is free.
`timescale 1ns / 1ps

module ray_trace_log_odds_grid_update
    import rtlog_pkg::*;
#(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int ODDS_BITS = DEF_ODDS_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_col [11:0], start_row [23:12], end_col [35:24], end_row [47:36]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // command [1:0]
    input  logic [CMD_W-1:0]      s_tuser,
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cell_value [15:0], cells_touched [25:16], zero [31:26]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // in_grid [0]
    output logic                  m_tuser,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = ((ODDS_BITS > VALUE_W) ? ODDS_BITS : VALUE_W) + 1;
    localparam int LIM_W  = COORD_W + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_RAY    = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_CLEAR  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    // configuration
    logic signed [STEP_W-1:0] free_step_reg;
    logic signed [STEP_W-1:0] occupied_step_reg;
    logic signed [STEP_W-1:0] odds_floor_reg;
    logic signed [STEP_W-1:0] odds_ceiling_reg;
    logic [SIZE_W-1:0]        active_cols_reg;
    logic [SIZE_W-1:0]        active_rows_reg;

    // sequencer
    logic [2:0]               state_reg, state_next;
    logic [CMD_W-1:0]         cmd_reg;
    logic signed [COORD_W-1:0] c0_reg, r0_reg, c1_reg, r1_reg;
    logic [ADDR_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                     clr_cmd_reg, clr_cmd_next;
    logic [VALUE_W-1:0]       res_value_reg, res_value_next;
    logic                     res_ok_reg, res_ok_next;
    logic [TOUCH_W-1:0]       res_touched_reg, res_touched_next;

    // output register
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0]       m_value_reg;
    logic                     m_ok_reg;
    logic [TOUCH_W-1:0]       m_touched_reg;
    logic                     out_load;

    // update pipeline
    logic                     upd_wen_reg;
    logic [ADDR_W-1:0]        upd_addr_reg;
    logic signed [STEP_W-1:0] upd_step_reg;

    logic                     start_in;
    logic                     end_in;
    logic                     walk_load;
    rtlog_cell_t              walk_cell;
    logic [COL_W-1:0]         cell_col;
    logic [ROW_W-1:0]         cell_row;

    logic                     mem_rd_en;
    logic [ADDR_W-1:0]        mem_rd_addr;
    logic [ODDS_BITS-1:0]     mem_rd_data;
    logic                     mem_wr_en;
    logic [ADDR_W-1:0]        mem_wr_addr;
    logic [ODDS_BITS-1:0]     mem_wr_data;
    logic signed [ODDS_BITS-1:0] upd_value;
    logic signed [SUM_W-1:0]  rd_ext;

    function automatic logic coord_ok(input logic signed [COORD_W-1:0] v,
                                      input logic [SIZE_W-1:0] act,
                                      input logic [LIM_W-1:0] lim);
        logic [LIM_W-1:0] u;
        u = LIM_W'(v[COORD_W-2:0]);
        return !v[COORD_W-1] && (u < LIM_W'(act)) && (u < lim);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] row);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLS)) + ADDR_W'(col);
    endfunction

    assign start_in = coord_ok(c0_reg, active_cols_reg, LIM_W'(MAX_COLS))
                   && coord_ok(r0_reg, active_rows_reg, LIM_W'(MAX_ROWS));
    assign end_in   = coord_ok(c1_reg, active_cols_reg, LIM_W'(MAX_COLS))
                   && coord_ok(r1_reg, active_rows_reg, LIM_W'(MAX_ROWS));

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_step_reg     <= RST_FREE_STEP;
            occupied_step_reg <= RST_OCCUPIED_STEP;
            odds_floor_reg    <= RST_ODDS_FLOOR;
            odds_ceiling_reg  <= RST_ODDS_CEILING;
            active_cols_reg   <= RST_ACTIVE_COLS;
            active_rows_reg   <= RST_ACTIVE_ROWS;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FREE_STEP:     free_step_reg     <= cfg_data;
                CFG_OCCUPIED_STEP: occupied_step_reg <= cfg_data;
                CFG_ODDS_FLOOR:    odds_floor_reg    <= cfg_data;
                CFG_ODDS_CEILING:  odds_ceiling_reg  <= cfg_data;
                CFG_ACTIVE_COLS:   active_cols_reg   <= cfg_data[SIZE_W-1:0];
                CFG_ACTIVE_ROWS:   active_rows_reg   <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= s_tuser;
            c0_reg  <= s_tdata[11:0];
            r0_reg  <= s_tdata[23:12];
            c1_reg  <= s_tdata[35:24];
            r1_reg  <= s_tdata[47:36];
        end
    end

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign walk_load = (state_reg == ST_DECODE) && (cmd_reg == CMD_RAY)
                    && start_in && end_in;
    assign rd_ext = SUM_W'($signed(mem_rd_data));

    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_cmd_next     = clr_cmd_reg;
        res_value_next   = res_value_reg;
        res_ok_next      = res_ok_reg;
        res_touched_next = res_touched_reg;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = addr_of(cell_col, cell_row);

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                res_value_next   = '0;
                res_ok_next      = 1'b0;
                res_touched_next = '0;
                state_next       = ST_DONE;
                case (cmd_reg)
                    CMD_RAY: begin
                        if (start_in && end_in) begin
                            res_ok_next = 1'b1;
                            state_next  = ST_RAY;
                        end
                    end
                    CMD_READ: begin
                        if (start_in) begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = addr_of(c0_reg[COL_W-1:0], r0_reg[ROW_W-1:0]);
                            state_next  = ST_READ;
                        end
                    end
                    CMD_CLEAR: begin
                        clr_cnt_next = '0;
                        clr_cmd_next = 1'b1;
                        state_next   = ST_CLEAR;
                    end
                    default: ;
                endcase
            end
            ST_RAY: begin
                if (walk_cell.valid) begin
                    mem_rd_en = 1'b1;
                    if (res_touched_reg != {TOUCH_W{1'b1}}) begin
                        res_touched_next = res_touched_reg + TOUCH_W'(1);
                    end
                    if (walk_cell.last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // last cell is written in this cycle
                state_next = ST_DONE;
            end
            ST_READ: begin
                res_value_next = rd_ext[VALUE_W-1:0];
                res_ok_next    = 1'b1;
                state_next     = ST_DONE;
            end
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next   = clr_cmd_reg ? ST_DONE : ST_IDLE;
                    clr_cmd_next = 1'b0;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            clr_cmd_reg <= 1'b0;
            upd_wen_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_cmd_reg <= clr_cmd_next;
            upd_wen_reg <= (state_reg == ST_RAY) && walk_cell.valid;
        end
    end

    always_ff @(posedge aclk) begin
        res_value_reg   <= res_value_next;
        res_ok_reg      <= res_ok_next;
        res_touched_reg <= res_touched_next;
        upd_addr_reg    <= mem_rd_addr;
        upd_step_reg    <= walk_cell.last ? occupied_step_reg : free_step_reg;
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_reg   <= res_value_reg;
            m_ok_reg      <= res_ok_reg;
            m_touched_reg <= res_touched_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - TOUCH_W){1'b0}}, m_touched_reg, m_value_reg};
    assign m_tuser  = m_ok_reg;

    // store write port: clearing pass or the read-modify-write of the ray
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_reg;
            mem_wr_data = '0;
        end else begin
            mem_wr_en   = upd_wen_reg;
            mem_wr_addr = upd_addr_reg;
            mem_wr_data = upd_value;
        end
    end

    rtlog_line_walker #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (walk_load),
        .start_col (c0_reg[COL_W-1:0]),
        .start_row (r0_reg[ROW_W-1:0]),
        .end_col   (c1_reg[COL_W-1:0]),
        .end_row   (r1_reg[ROW_W-1:0]),
        .cur_cell  (walk_cell),
        .cell_col  (cell_col),
        .cell_row  (cell_row)
    );

    rtlog_cell_update #(
        .ODDS_BITS (ODDS_BITS)
    ) u_update (
        .old_value    ($signed(mem_rd_data)),
        .step         (upd_step_reg),
        .odds_floor   (odds_floor_reg),
        .odds_ceiling (odds_ceiling_reg),
        .new_value    (upd_value)
    );

    rtlog_odds_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .WIDTH  (ODDS_BITS)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // the store is never written between requests
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_wr_en)
        else $error("store written while idle");

    // the walker only runs while a ray is in work
    a_walk_in_ray: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_cell.valid |-> (state_reg == ST_RAY))
        else $error("line walker active outside ray state");

    // the end cell is followed by the drain cycle that writes it back
    a_end_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (walk_cell.valid && walk_cell.last) |=> (state_reg == ST_DRAIN) && upd_wen_reg)
        else $error("end cell not written back");

    // a result with touched cells always lay inside the grid
    a_touch_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[25:16] != 10'd0)) |-> m_tuser)
        else $error("cells touched outside the grid");

endmodule

// ----- tb/rtlog_grid_checker.sv -----
// rtlog_grid_checker: watches the request, result and register write channels
// of the log-odds grid block, predicts every result and compares it.
// Depends on rtlog_pkg only.
`timescale 1ns / 1ps

module rtlog_grid_checker
    import rtlog_pkg::*;
#(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int ODDS_BITS = DEF_ODDS_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    failures,
    output int                    pending
);

    localparam int ODDS_HI = (1 << (ODDS_BITS - 1)) - 1;
    localparam int ODDS_LO = -(1 << (ODDS_BITS - 1));
    localparam int TOUCH_MAX = (1 << TOUCH_W) - 1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               in_grid;
        logic [TOUCH_W-1:0] touched;
    } grid_result_t;

    int odds_grid [MAX_COLS*MAX_ROWS];
    int free_step_q, occupied_step_q, floor_q, ceiling_q;
    int cols_q, rows_q;

    grid_result_t odds_results_due [$];

    initial begin
        for (int i = 0; i < MAX_COLS*MAX_ROWS; i++) odds_grid[i] = 0;
        free_step_q     = int'(RST_FREE_STEP);
        occupied_step_q = int'(RST_OCCUPIED_STEP);
        floor_q         = int'(RST_ODDS_FLOOR);
        ceiling_q       = int'(RST_ODDS_CEILING);
        cols_q          = int'(RST_ACTIVE_COLS);
        rows_q          = int'(RST_ACTIVE_ROWS);
        failures        = 0;
        pending         = 0;
    end

    function automatic logic in_active(int c, int r);
        int cu, ru;
        cu = (cols_q < MAX_COLS) ? cols_q : MAX_COLS;
        ru = (rows_q < MAX_ROWS) ? rows_q : MAX_ROWS;
        return (c >= 0) && (r >= 0) && (c < cu) && (r < ru);
    endfunction

    // add a step to one cell: ceiling first, then floor, then the storage range
    function automatic void bump_cell(int c, int r, int step);
        int idx, v;
        idx = r * MAX_COLS + c;
        v = odds_grid[idx] + step;
        if (v > ceiling_q) v = ceiling_q;
        if (v < floor_q) v = floor_q;
        if (v > ODDS_HI) v = ODDS_HI;
        if (v < ODDS_LO) v = ODDS_LO;
        odds_grid[idx] = v;
    endfunction

    task automatic update_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FREE_STEP:     free_step_q     = int'($signed(data[STEP_W-1:0]));
            CFG_OCCUPIED_STEP: occupied_step_q = int'($signed(data[STEP_W-1:0]));
            CFG_ODDS_FLOOR:    floor_q         = int'($signed(data[STEP_W-1:0]));
            CFG_ODDS_CEILING:  ceiling_q       = int'($signed(data[STEP_W-1:0]));
            CFG_ACTIVE_COLS:   cols_q          = int'(data[SIZE_W-1:0]);
            CFG_ACTIVE_ROWS:   rows_q          = int'(data[SIZE_W-1:0]);
            default: ;
        endcase
    endtask

    // walks the line for a ray or serves a read or clear, updates the grid copy and builds the result
    task automatic walk_and_update(input logic [CMD_W-1:0] cmd,
                                   input logic [S_TDATA_W-1:0] cells,
                                   output grid_result_t res);
        int c0, r0, c1, r1, dx, dy, sx, sy, err, e2, n, idx;
        logic done;
        c0 = int'($signed(cells[COORD_W-1:0]));
        r0 = int'($signed(cells[2*COORD_W-1:COORD_W]));
        c1 = int'($signed(cells[3*COORD_W-1:2*COORD_W]));
        r1 = int'($signed(cells[4*COORD_W-1:3*COORD_W]));
        res = '0;
        case (cmd)
            CMD_RAY: begin
                if (in_active(c0, r0) && in_active(c1, r1)) begin
                    dx = (c1 > c0) ? c1 - c0 : c0 - c1;
                    dy = (r1 > r0) ? r1 - r0 : r0 - r1;
                    sx = (c0 < c1) ? 1 : -1;
                    sy = (r0 < r1) ? 1 : -1;
                    err = dx - dy;
                    n = 0;
                    done = 1'b0;
                    while (!done) begin
                        n++;
                        if (c0 == c1 && r0 == r1) begin
                            bump_cell(c0, r0, occupied_step_q);
                            done = 1'b1;
                        end else begin
                            bump_cell(c0, r0, free_step_q);
                            e2 = err * 2;
                            if (e2 > -dy) begin
                                err -= dy;
                                c0 += sx;
                            end
                            if (e2 < dx) begin
                                err += dx;
                                r0 += sy;
                            end
                        end
                    end
                    res.in_grid = 1'b1;
                    res.touched = TOUCH_W'((n > TOUCH_MAX) ? TOUCH_MAX : n);
                end
            end
            CMD_READ: begin
                if (in_active(c0, r0)) begin
                    idx = r0 * MAX_COLS + c0;
                    res.value   = VALUE_W'(odds_grid[idx]);
                    res.in_grid = 1'b1;
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < MAX_COLS*MAX_ROWS; i++) odds_grid[i] = 0;
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin : watch
        grid_result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) update_register(cfg_index, cfg_data);
            // compare before predicting so a result never meets its own request
            if (m_tvalid && m_tready) begin
                if (odds_results_due.size() == 0) begin
                    $error("result with no request outstanding: m_tdata %h m_tuser %b",
                           m_tdata, m_tuser);
                    failures++;
                end else begin
                    want = odds_results_due.pop_front();
                    if (m_tdata[VALUE_W-1:0] !== want.value) begin
                        $error("cell_value: expected %0d, got %0d",
                               $signed(want.value), $signed(m_tdata[VALUE_W-1:0]));
                        failures++;
                    end
                    if (m_tdata[VALUE_W+:TOUCH_W] !== want.touched) begin
                        $error("cells_touched: expected %0d, got %0d",
                               want.touched, m_tdata[VALUE_W+:TOUCH_W]);
                        failures++;
                    end
                    if (m_tdata[M_TDATA_W-1:VALUE_W+TOUCH_W] !== '0) begin
                        $error("m_tdata padding: expected 0, got %b",
                               m_tdata[M_TDATA_W-1:VALUE_W+TOUCH_W]);
                        failures++;
                    end
                    if (m_tuser !== want.in_grid) begin
                        $error("in_grid: expected %b, got %b", want.in_grid, m_tuser);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                walk_and_update(s_tuser, s_tdata, want);
                odds_results_due.push_back(want);
            end
            pending <= odds_results_due.size();
        end
    end

endmodule

// ----- tb/ray_trace_log_odds_grid_update_test.sv -----
// ray_trace_log_odds_grid_update_test: drives requests and register writes into
// the log-odds grid block and gives the verdict.
// Depends on rtlog_pkg, ray_trace_log_odds_grid_update and rtlog_grid_checker.
`timescale 1ns / 1ps

module ray_trace_log_odds_grid_update_test;
    import rtlog_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int PHASE_ITEMS  = 75;
    localparam int LONG_HOLD    = 2500;
    localparam int SETTLE       = 600;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = CMD_RAY;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FREE_STEP;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int failures;
    int pending;
    int cycle_count = 0;
    int requests_sent = 0;
    int grid_cols = DEF_MAX_COLS;
    int grid_rows = DEF_MAX_ROWS;

    ray_trace_log_odds_grid_update DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rtlog_grid_checker grid_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, stretches without any, and two long hold-offs
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (taken == 60 || taken == 400) stall = LONG_HOLD;
            else if ((taken / 40) % 3 == 1) stall = 0;
            else stall = $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input int sc, input int sr,
                                input int ec, input int er);
        int gap;
        if ((requests_sent / 40) % 3 == 2) gap = 0;
        else gap = $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {12'(er), 12'(ec), 12'(sr), 12'(sc)};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // wait until every request has its result back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_grid(input int fs, input int os, input int fl, input int cl,
                                input int cols, input int rows);
        write_reg(CFG_FREE_STEP, fs);
        write_reg(CFG_OCCUPIED_STEP, os);
        write_reg(CFG_ODDS_FLOOR, fl);
        write_reg(CFG_ODDS_CEILING, cl);
        write_reg(CFG_ACTIVE_COLS, cols);
        write_reg(CFG_ACTIVE_ROWS, rows);
        cfg_valid <= 1'b0;
        grid_cols = (cols < DEF_MAX_COLS) ? cols : DEF_MAX_COLS;
        grid_rows = (rows < DEF_MAX_ROWS) ? rows : DEF_MAX_ROWS;
    endtask

    function automatic int any_coord();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic int coord_in(int span);
        if (span == 0) return any_coord();
        return $urandom_range(0, span - 1);
    endfunction

    // a cell close to v, kept inside the span; any coordinate when the span is zero
    function automatic int coord_near(int v, int span);
        int t;
        if (span == 0) return any_coord();
        t = v + int'($urandom_range(0, 32)) - 16;
        if (t < 0) t = 0;
        if (t > span - 1) t = span - 1;
        return t;
    endfunction

    function automatic int rand16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic random_request();
        int pick, sc, sr, ec, er;
        pick = $urandom_range(0, 99);
        sc = coord_in(grid_cols);
        sr = coord_in(grid_rows);
        if ($urandom_range(0, 1)) begin
            ec = coord_near(sc, grid_cols);
            er = coord_near(sr, grid_rows);
        end else begin
            ec = coord_in(grid_cols);
            er = coord_in(grid_rows);
        end
        if (pick < 55) begin
            send_request(CMD_RAY, sc, sr, ec, er);
        end else if (pick < 80) begin
            send_request(CMD_READ, sc, sr, any_coord(), any_coord());
        end else if (pick < 85) begin
            send_request(CMD_RAY, sc, sr, any_coord(), any_coord());
        end else if (pick < 90) begin
            send_request(CMD_RAY, any_coord(), any_coord(), ec, er);
        end else if (pick < 97) begin
            send_request(CMD_READ, any_coord(), any_coord(), any_coord(), any_coord());
        end else begin
            send_request(CMD_SPARE, any_coord(), any_coord(), any_coord(), any_coord());
        end
    endtask

    task automatic run_phase(input int fs, input int os, input int fl, input int cl,
                             input int cols, input int rows);
        drain();
        program_grid(fs, os, fl, cl, cols, rows);
        repeat (PHASE_ITEMS) random_request();
    endtask

    initial begin : stimulus
        int lo, hi;
        do @(posedge aclk); while (!aresetn);

        // directed part on the reset settings
        send_request(CMD_READ, 0, 0, 0, 0);
        send_request(CMD_RAY, 0, 0, 0, 0);
        send_request(CMD_READ, 0, 0, 0, 0);
        send_request(CMD_RAY, 0, 0, 511, 511);
        send_request(CMD_RAY, 511, 0, 0, 511);
        send_request(CMD_RAY, 0, 7, 511, 7);
        send_request(CMD_RAY, 3, 0, 9, 511);
        send_request(CMD_READ, 511, 511, 0, 0);
        send_request(CMD_READ, 255, 255, 0, 0);
        send_request(CMD_RAY, 5, 5, 512, 5);
        send_request(CMD_RAY, -1, 4, 6, 6);
        send_request(CMD_RAY, -2048, 2047, 2047, -2048);
        send_request(CMD_READ, -2048, -2048, 2047, 2047);
        send_request(CMD_READ, 512, 0, -1, -1);
        send_request(CMD_READ, -1, -1, -1, -1);
        send_request(CMD_SPARE, 100, 100, 200, 200);
        send_request(CMD_CLEAR, 0, 0, 0, 0);
        send_request(CMD_READ, 511, 511, 0, 0);
        send_request(CMD_READ, 0, 7, 0, 0);
        send_request(CMD_RAY, 100, 200, 101, 200);
        send_request(CMD_READ, 100, 200, 0, 0);

        // extreme steps on a tiny grid drive cells into both clamps
        run_phase(-32768, 32767, -32768, 32767, 8, 8);
        // floor above ceiling, sizes beyond the store
        run_phase(300, -500, 100, -100, 1023, 1023);
        // zero width: nothing is inside
        run_phase(rand16(), rand16(), -1280, 1280, 0, 512);
        run_phase(-102, 217, -1280, 1280, 1, 512);
        run_phase(int'($urandom_range(0, 4000)) - 2000, int'($urandom_range(0, 4000)) - 2000,
                  -600, 900, 16, 3);
        // grow back: cells outside the shrunk grid reappear
        run_phase(-102, 217, -1280, 1280, 512, 512);
        lo = rand16();
        hi = rand16();
        run_phase(rand16(), rand16(), lo, hi, $urandom_range(0, 1023), $urandom_range(0, 1023));
        run_phase(-102, 217, -1280, 1280, 40, 25);

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
